// ===== rtl/core/tgd_pkg.sv =====
// Shared types, constants and helper functions of the touch gesture debouncer.
`timescale 1ns / 1ps

package tgd_pkg;

	localparam int COORD_BITS = 12;
	localparam int COUNT_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS + 1;
	localparam int APB_AW     = 5;
	localparam int APB_DW     = 32;

	typedef enum logic [1:0] {
		ORIENT_MIRROR_X    = 2'd0,
		ORIENT_SWAP        = 2'd1,
		ORIENT_SWAP_MIRROR = 2'd2,
		ORIENT_MIRROR_Y    = 2'd3
	} orient_t;

	typedef enum logic [2:0] {
		REG_ORIENT   = 3'd0,
		REG_MOVE_THR = 3'd1,
		REG_DEBOUNCE = 3'd2,
		REG_RELEASE  = 3'd3,
		REG_HOLD     = 3'd4,
		REG_WIDTH    = 3'd5,
		REG_HEIGHT   = 3'd6
	} reg_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_DOWN = 3'd1,
		EV_MOVE = 3'd2,
		EV_HOLD = 3'd3,
		EV_UP   = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		GS_IDLE     = 2'd0,
		GS_DEBOUNCE = 2'd1,
		GS_PRESSED  = 2'd2,
		GS_HOLD     = 2'd3
	} gs_code_t;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_DEBOUNCE = 4'b0010,
		ST_PRESSED  = 4'b0100,
		ST_HOLD     = 4'b1000
	} state_t;

	typedef struct packed {
		orient_t                orientation_mode;
		logic [COORD_BITS-1:0]  move_threshold;
		logic [COUNT_BITS-1:0]  debounce_samples;
		logic [COUNT_BITS-1:0]  release_samples;
		logic [COUNT_BITS-1:0]  hold_samples;
		logic [SIZE_BITS-1:0]   display_width;
		logic [SIZE_BITS-1:0]   display_height;
	} cfg_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

// ===== rtl/core/tgd_map.sv =====
// Orientation mapping and clamping of a raw touch point to display space.
`timescale 1ns / 1ps

module tgd_map import tgd_pkg::*; (
	input  cfg_t                  cfg,
	input  logic [COORD_BITS-1:0] raw_x,
	input  logic [COORD_BITS-1:0] raw_y,
	output logic [COORD_BITS-1:0] map_x,
	output logic [COORD_BITS-1:0] map_y
);

	localparam int SW = COORD_BITS + 2;
	localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(1) << COORD_BITS;

	logic [SIZE_BITS-1:0]  w_eff;
	logic [SIZE_BITS-1:0]  h_eff;
	logic [COORD_BITS-1:0] w_m1;
	logic [COORD_BITS-1:0] h_m1;
	logic signed [SW-1:0]  xs;
	logic signed [SW-1:0]  ys;

	function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
		if (s == '0) begin
			return SIZE_BITS'(1);
		end else if (s > SIZE_MAX) begin
			return SIZE_MAX;
		end else begin
			return s;
		end
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
			input logic [SIZE_BITS-1:0] size);
		if (v < 0) begin
			return '0;
		end else if (v >= $signed({1'b0, size})) begin
			return COORD_BITS'(size - 1'b1);
		end else begin
			return v[COORD_BITS-1:0];
		end
	endfunction

	assign w_eff = eff_size(cfg.display_width);
	assign h_eff = eff_size(cfg.display_height);
	assign w_m1  = COORD_BITS'(w_eff - 1'b1);
	assign h_m1  = COORD_BITS'(h_eff - 1'b1);

	always_comb begin
		unique case (cfg.orientation_mode)
			ORIENT_SWAP: begin
				xs = $signed({2'b00, raw_y});
				ys = $signed({2'b00, raw_x});
			end
			ORIENT_SWAP_MIRROR: begin
				xs = $signed({2'b00, w_m1}) - $signed({2'b00, raw_y});
				ys = $signed({2'b00, h_m1}) - $signed({2'b00, raw_x});
			end
			ORIENT_MIRROR_Y: begin
				xs = $signed({2'b00, raw_x});
				ys = $signed({2'b00, h_m1}) - $signed({2'b00, raw_y});
			end
			default: begin
				xs = $signed({2'b00, w_m1}) - $signed({2'b00, raw_x});
				ys = $signed({2'b00, raw_y});
			end
		endcase
	end

	assign map_x = clamp(xs, w_eff);
	assign map_y = clamp(ys, h_eff);

endmodule

// ===== rtl/core/touch_gesture_debouncer_top.sv =====
// Top level of the touch gesture debouncer: register port, sample stage and gesture machine.
//
// Channel  Direction  Handshake          Contents
// in       request    in_valid/in_ready  read_error, touch_count, raw_x, raw_y
// out      result     out_valid/out_ready status_error, touch_event, gesture_state,
//                                        point_x, point_y, contacts
// cfg      APB write  psel/penable/pready 7 registers at byte address 4*i
//
// One request per cycle while out_ready does not hold the output: an accepted request
// is registered in the input stage, and its result is then registered in the output
// register, which raises out_valid. The output register holds a result until taken;
// the input stage takes a request whenever it is empty or its request moves on into a
// free or emptying output register. Asynchronous reset empties both stages, idles the
// gesture state and loads the register defaults.
`timescale 1ns / 1ps

module touch_gesture_debouncer_top import tgd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  read_error,
	input  logic [3:0]            touch_count,
	input  logic [COORD_BITS-1:0] raw_x,
	input  logic [COORD_BITS-1:0] raw_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  status_error,
	output logic [2:0]            touch_event,
	output logic [1:0]            gesture_state,
	output logic [COORD_BITS-1:0] point_x,
	output logic [COORD_BITS-1:0] point_y,
	output logic [3:0]            contacts
);

	cfg_t cfg_q;
	reg_t reg_sel;
	logic cfg_wr;

	logic                  valid_s1;
	logic                  read_error_s1;
	logic [3:0]            touch_count_s1;
	logic [COORD_BITS-1:0] raw_x_s1;
	logic [COORD_BITS-1:0] raw_y_s1;

	state_t                state_q, state_d;
	logic [COORD_BITS-1:0] ref_x_q, ref_y_q, last_x_q, last_y_q;
	logic [COORD_BITS-1:0] ref_x_d, ref_y_d, last_x_d, last_y_d;
	logic [COUNT_BITS-1:0] stable_q, release_q, hold_q;
	logic [COUNT_BITS-1:0] stable_d, release_d, hold_d;
	logic [COUNT_BITS-1:0] stable_inc, release_inc, hold_inc;

	logic                  out_valid_q;
	logic                  status_error_q;
	event_t                event_q, event_d;
	gs_code_t              gs_q, gs_d;
	logic [COORD_BITS-1:0] point_x_q, point_y_q;
	logic [3:0]            contacts_q;

	logic                  advance;
	logic                  touched;
	logic                  still;
	logic [COORD_BITS-1:0] map_x, map_y;
	logic [COORD_BITS-1:0] new_x, new_y;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = reg_t'(paddr[APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_sel)
			REG_ORIENT:   prdata = APB_DW'(cfg_q.orientation_mode);
			REG_MOVE_THR: prdata = APB_DW'(cfg_q.move_threshold);
			REG_DEBOUNCE: prdata = APB_DW'(cfg_q.debounce_samples);
			REG_RELEASE:  prdata = APB_DW'(cfg_q.release_samples);
			REG_HOLD:     prdata = APB_DW'(cfg_q.hold_samples);
			REG_WIDTH:    prdata = APB_DW'(cfg_q.display_width);
			REG_HEIGHT:   prdata = APB_DW'(cfg_q.display_height);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation_mode <= ORIENT_MIRROR_X;
			cfg_q.move_threshold   <= COORD_BITS'(8);
			cfg_q.debounce_samples <= COUNT_BITS'(3);
			cfg_q.release_samples  <= COUNT_BITS'(3);
			cfg_q.hold_samples     <= COUNT_BITS'(50);
			cfg_q.display_width    <= SIZE_BITS'(320);
			cfg_q.display_height   <= SIZE_BITS'(480);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ORIENT:   cfg_q.orientation_mode <= orient_t'(pwdata[1:0]);
				REG_MOVE_THR: cfg_q.move_threshold   <= pwdata[COORD_BITS-1:0];
				REG_DEBOUNCE: cfg_q.debounce_samples <= pwdata[COUNT_BITS-1:0];
				REG_RELEASE:  cfg_q.release_samples  <= pwdata[COUNT_BITS-1:0];
				REG_HOLD:     cfg_q.hold_samples     <= pwdata[COUNT_BITS-1:0];
				REG_WIDTH:    cfg_q.display_width    <= pwdata[SIZE_BITS-1:0];
				REG_HEIGHT:   cfg_q.display_height   <= pwdata[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			read_error_s1  <= read_error;
			touch_count_s1 <= touch_count;
			raw_x_s1       <= raw_x;
			raw_y_s1       <= raw_y;
		end
	end

	tgd_map u_map (
		.cfg   (cfg_q),
		.raw_x (raw_x_s1),
		.raw_y (raw_y_s1),
		.map_x (map_x),
		.map_y (map_y)
	);

	// gesture machine
	assign touched     = touch_count_s1 != 4'd0;
	assign new_x       = touched ? map_x : last_x_q;
	assign new_y       = touched ? map_y : last_y_q;
	assign still       = (abs_diff(new_x, ref_x_q) <= cfg_q.move_threshold) &&
	                     (abs_diff(new_y, ref_y_q) <= cfg_q.move_threshold);
	assign stable_inc  = sat_inc(stable_q);
	assign release_inc = sat_inc(release_q);
	assign hold_inc    = sat_inc(hold_q);

	always_comb begin
		state_d   = state_q;
		ref_x_d   = ref_x_q;
		ref_y_d   = ref_y_q;
		last_x_d  = new_x;
		last_y_d  = new_y;
		stable_d  = stable_q;
		release_d = release_q;
		hold_d    = hold_q;
		event_d   = EV_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (touched) begin
					state_d   = ST_DEBOUNCE;
					ref_x_d   = new_x;
					ref_y_d   = new_y;
					stable_d  = COUNT_BITS'(1);
					release_d = '0;
					hold_d    = '0;
				end
			end
			ST_DEBOUNCE: begin
				if (!touched) begin
					state_d   = ST_IDLE;
					stable_d  = '0;
					release_d = '0;
					hold_d    = '0;
				end else begin
					if (still) begin
						stable_d = stable_inc;
					end else begin
						ref_x_d  = new_x;
						ref_y_d  = new_y;
						stable_d = COUNT_BITS'(1);
					end
					if (stable_d >= cfg_q.debounce_samples) begin
						state_d  = ST_PRESSED;
						event_d  = EV_DOWN;
						ref_x_d  = new_x;
						ref_y_d  = new_y;
						stable_d = '0;
					end
				end
			end
			ST_PRESSED, ST_HOLD: begin
				if (!touched) begin
					release_d = release_inc;
					if (release_inc >= cfg_q.release_samples) begin
						state_d   = ST_IDLE;
						event_d   = EV_UP;
						stable_d  = '0;
						release_d = '0;
						hold_d    = '0;
					end
				end else begin
					release_d = '0;
					if (!still) begin
						ref_x_d = new_x;
						ref_y_d = new_y;
						hold_d  = '0;
						state_d = ST_PRESSED;
						event_d = EV_MOVE;
					end else if (state_q == ST_PRESSED) begin
						hold_d = hold_inc;
						if (hold_inc >= cfg_q.hold_samples) begin
							state_d = ST_HOLD;
							event_d = EV_HOLD;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		unique case (read_error_s1 ? state_q : state_d)
			ST_DEBOUNCE: gs_d = GS_DEBOUNCE;
			ST_PRESSED:  gs_d = GS_PRESSED;
			ST_HOLD:     gs_d = GS_HOLD;
			default:     gs_d = GS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ref_x_q   <= '0;
			ref_y_q   <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			stable_q  <= '0;
			release_q <= '0;
			hold_q    <= '0;
		end else if (advance && !read_error_s1) begin
			state_q   <= state_d;
			ref_x_q   <= ref_x_d;
			ref_y_q   <= ref_y_d;
			last_x_q  <= last_x_d;
			last_y_q  <= last_y_d;
			stable_q  <= stable_d;
			release_q <= release_d;
			hold_q    <= hold_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_error_q <= read_error_s1;
			event_q        <= read_error_s1 ? EV_NONE : event_d;
			gs_q           <= gs_d;
			point_x_q      <= read_error_s1 ? last_x_q : new_x;
			point_y_q      <= read_error_s1 ? last_y_q : new_y;
			contacts_q     <= read_error_s1 ? 4'd0 : touch_count_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign status_error  = status_error_q;
	assign touch_event   = event_q;
	assign gesture_state = gs_q;
	assign point_x       = point_x_q;
	assign point_y       = point_y_q;
	assign contacts      = contacts_q;

endmodule
